@@ hdl/tgadec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the TGA RLE image decoder.
// No dependencies; imported by every module of the decoder.
package tgadec_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_DIMS = 3'd1,
        PH_PKT  = 3'd2,
        PH_PIX  = 3'd3,
        PH_SKIP = 3'd4
    } t_phase;

    // Result kinds, carried on tuser
    typedef enum logic [1:0] {
        KIND_INFO  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TYPE    = 3'd1,
        ERR_SIZE    = 3'd2,
        ERR_OVERRUN = 3'd3,
        ERR_SHORT   = 3'd4
    } t_err;

    // One result request passed from the parser to the output side
    typedef struct packed {
        t_kind       kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        has_alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_res;
        t_err        error_code;
        logic        last;
    } t_result;

    // Header byte positions
    localparam logic [4:0] HDR_TYPE_BYTE = 5'd2;
    localparam logic [4:0] HDR_TYPE_LAST = 5'd11;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;

    // Header byte values
    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // Stream widths
    localparam int TDATA_W = 80;
    localparam int TUSER_W = 2;

endpackage

@@ hdl/tgadec_front.sv @@
`timescale 1ns / 1ps
// Front end of the TGA decoder: header parser, packet and pixel tracking.
// Emits one result request per byte at most. Depends on tgadec_pkg.
module tgadec_front
    import tgadec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_file,
    output logic       o_push,
    output t_result    o_result
);

    t_phase      r_phase, n_phase, w_phase_step;
    logic [4:0]  r_header_index, n_header_index;
    logic        r_rle_mode, n_rle_mode;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_four_bytes, n_four_bytes;
    logic [31:0] r_pixels_left, n_pixels_left;
    logic [7:0]  r_packet_left, n_packet_left;
    logic        r_packet_is_run, n_packet_is_run;
    logic [23:0] r_colour, n_colour;
    logic [1:0]  r_byte_in_pixel, n_byte_in_pixel;

    logic        w_type_ok;
    logic        w_dims_bad;
    logic [7:0]  w_count;
    logic        w_overrun;
    logic        w_pix_store;
    logic [7:0]  w_rep_raw;
    logic [7:0]  w_rep;
    logic [31:0] w_pixels_after;
    logic [7:0]  w_packet_after;
    logic [31:0] w_area;

    assign w_type_ok = (r_header_index == HDR_TYPE_BYTE) ?
                       ((i_data_byte == TYPE_RAW) || (i_data_byte == TYPE_RLE)) :
                       (i_data_byte == 8'd0);
    assign w_dims_bad = (r_width == 16'd0) || (r_height == 16'd0) ||
                        ((i_data_byte != DEPTH_24) && (i_data_byte != DEPTH_32));
    // Raw and run packets both carry count-1 in the low seven bits
    assign w_count     = {1'b0, i_data_byte[6:0]} + 8'd1;
    assign w_overrun   = {24'h0, w_count} > r_pixels_left;
    assign w_pix_store = r_byte_in_pixel < (r_four_bytes ? 2'd3 : 2'd2);
    assign w_rep_raw   = (r_rle_mode && r_packet_is_run) ? r_packet_left : 8'd1;
    assign w_rep       = ({24'h0, w_rep_raw} > r_pixels_left) ? r_pixels_left[7:0] : w_rep_raw;
    assign w_pixels_after = r_pixels_left - {24'h0, w_rep};
    assign w_packet_after = (w_rep > r_packet_left) ? 8'd0 : (r_packet_left - w_rep);
    assign w_area = {16'h0, r_width} * {16'h0, r_height};

    // Next phase
    always_comb begin
        w_phase_step = r_phase;
        case (r_phase)
            PH_TYPE: begin
                if (!w_type_ok) begin
                    w_phase_step = PH_SKIP;
                end else if (r_header_index >= HDR_TYPE_LAST) begin
                    w_phase_step = PH_DIMS;
                end
            end
            PH_DIMS: begin
                if (r_header_index == HDR_DEPTH) begin
                    if (w_dims_bad) begin
                        w_phase_step = PH_SKIP;
                    end
                end else if (r_header_index > HDR_DEPTH) begin
                    w_phase_step = r_rle_mode ? PH_PKT : PH_PIX;
                end
            end
            PH_PKT: begin
                w_phase_step = w_overrun ? PH_SKIP : PH_PIX;
            end
            PH_PIX: begin
                if (!w_pix_store) begin
                    if (w_pixels_after == 32'd0) begin
                        w_phase_step = PH_SKIP;
                    end else if (r_rle_mode && (w_packet_after == 8'd0)) begin
                        w_phase_step = PH_PKT;
                    end
                end
            end
            default: begin
                w_phase_step = r_phase;
            end
        endcase
        n_phase = r_phase;
        if (i_accept) begin
            n_phase = i_end_of_file ? PH_TYPE : w_phase_step;
        end
    end

    // Datapath and result
    always_comb begin
        n_header_index  = r_header_index;
        n_rle_mode      = r_rle_mode;
        n_width         = r_width;
        n_height        = r_height;
        n_four_bytes    = r_four_bytes;
        n_pixels_left   = r_pixels_left;
        n_packet_left   = r_packet_left;
        n_packet_is_run = r_packet_is_run;
        n_colour        = r_colour;
        n_byte_in_pixel = r_byte_in_pixel;
        o_push          = 1'b0;
        o_result        = '0;
        if (i_accept) begin
            case (r_phase)
                PH_TYPE: begin
                    if (r_header_index == HDR_TYPE_BYTE) begin
                        n_rle_mode = (i_data_byte == TYPE_RLE);
                    end
                    if (!w_type_ok) begin
                        o_push              = 1'b1;
                        o_result.kind       = KIND_ERROR;
                        o_result.error_code = ERR_TYPE;
                        o_result.last       = 1'b1;
                    end else begin
                        n_header_index = r_header_index + 5'd1;
                    end
                end
                PH_DIMS: begin
                    case (r_header_index)
                        HDR_WIDTH_LO:  n_width  = {8'h0, i_data_byte};
                        HDR_WIDTH_HI:  n_width  = {i_data_byte, r_width[7:0]};
                        HDR_HEIGHT_LO: n_height = {8'h0, i_data_byte};
                        HDR_HEIGHT_HI: n_height = {i_data_byte, r_height[7:0]};
                        HDR_DEPTH: begin
                            n_four_bytes = (i_data_byte == DEPTH_32);
                            if (w_dims_bad) begin
                                o_push              = 1'b1;
                                o_result.kind       = KIND_ERROR;
                                o_result.error_code = ERR_SIZE;
                                o_result.last       = 1'b1;
                            end
                        end
                        default: begin
                            // Descriptor byte: announce the image
                            o_push                = 1'b1;
                            o_result.kind         = KIND_INFO;
                            o_result.image_width  = r_width;
                            o_result.image_height = r_height;
                            o_result.has_alpha    = r_four_bytes;
                            n_pixels_left         = w_area;
                            n_byte_in_pixel       = 2'd0;
                            n_colour              = 24'h0;
                        end
                    endcase
                    if (w_phase_step == PH_DIMS) begin
                        n_header_index = r_header_index + 5'd1;
                    end
                end
                PH_PKT: begin
                    n_packet_is_run = i_data_byte[7];
                    if (w_overrun) begin
                        o_push              = 1'b1;
                        o_result.kind       = KIND_ERROR;
                        o_result.error_code = ERR_OVERRUN;
                        o_result.last       = 1'b1;
                    end else begin
                        n_packet_left   = w_count;
                        n_byte_in_pixel = 2'd0;
                        n_colour        = 24'h0;
                    end
                end
                PH_PIX: begin
                    if (w_pix_store) begin
                        case (r_byte_in_pixel)
                            2'd0:    n_colour        = {16'h0, i_data_byte};
                            2'd1:    n_colour[15:8]  = i_data_byte;
                            2'd2:    n_colour[23:16] = i_data_byte;
                            default: n_colour        = r_colour;
                        endcase
                        n_byte_in_pixel = r_byte_in_pixel + 2'd1;
                    end else begin
                        // Final stored byte: swap blue and red on the way out
                        o_push              = 1'b1;
                        o_result.kind       = KIND_PIXEL;
                        o_result.has_alpha  = r_four_bytes;
                        o_result.blue       = r_colour[7:0];
                        o_result.green      = r_colour[15:8];
                        o_result.red        = r_four_bytes ? r_colour[23:16] : i_data_byte;
                        o_result.alpha      = r_four_bytes ? i_data_byte : 8'h0;
                        o_result.repeat_res = w_rep;
                        o_result.last       = (w_pixels_after == 32'd0);
                        n_byte_in_pixel     = 2'd0;
                        n_pixels_left       = w_pixels_after;
                        if (r_rle_mode) begin
                            n_packet_left = w_packet_after;
                        end
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
            if (i_end_of_file) begin
                // Short stream replaces whatever this byte produced
                if (w_phase_step != PH_SKIP) begin
                    o_push              = 1'b1;
                    o_result            = '0;
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_SHORT;
                    o_result.last       = 1'b1;
                end
                n_header_index  = 5'd0;
                n_rle_mode      = 1'b0;
                n_width         = 16'h0;
                n_height        = 16'h0;
                n_four_bytes    = 1'b0;
                n_pixels_left   = 32'h0;
                n_packet_left   = 8'h0;
                n_packet_is_run = 1'b0;
                n_colour        = 24'h0;
                n_byte_in_pixel = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_TYPE;
            r_header_index  <= 5'd0;
            r_rle_mode      <= 1'b0;
            r_width         <= 16'h0;
            r_height        <= 16'h0;
            r_four_bytes    <= 1'b0;
            r_pixels_left   <= 32'h0;
            r_packet_left   <= 8'h0;
            r_packet_is_run <= 1'b0;
            r_colour        <= 24'h0;
            r_byte_in_pixel <= 2'd0;
        end else begin
            r_phase         <= n_phase;
            r_header_index  <= n_header_index;
            r_rle_mode      <= n_rle_mode;
            r_width         <= n_width;
            r_height        <= n_height;
            r_four_bytes    <= n_four_bytes;
            r_pixels_left   <= n_pixels_left;
            r_packet_left   <= n_packet_left;
            r_packet_is_run <= n_packet_is_run;
            r_colour        <= n_colour;
            r_byte_in_pixel <= n_byte_in_pixel;
        end
    end

endmodule

@@ hdl/tgadec_queue.sv @@
`timescale 1ns / 1ps
// Two-entry result queue between the parser and the output stage.
// Depends on tgadec_pkg for the result type.
module tgadec_queue
    import tgadec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_wr_data,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_rd_data,
    input  logic    i_pop
);

    t_result    r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_room    = (r_count != 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/tgadec_back.sv @@
`timescale 1ns / 1ps
// Output stage of the TGA decoder: holds one result and packs it onto the
// master stream. Depends on tgadec_pkg.
module tgadec_back
    import tgadec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_result            i_result,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [TDATA_W-1:0] o_tdata,
    output logic [TUSER_W-1:0] o_tuser,
    output logic               o_tlast
);

    logic    r_valid, n_valid;
    t_result r_result;

    // Load when empty or when the held result is being taken
    assign o_pop = i_valid && (!r_valid || i_tready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {4'h0, r_result.error_code, r_result.repeat_res,
                       r_result.alpha, r_result.blue, r_result.green, r_result.red,
                       r_result.has_alpha, r_result.image_height, r_result.image_width};
    assign o_tuser  = r_result.kind;
    assign o_tlast  = r_result.last;

endmodule

@@ hdl/tga_rle_image_decoder_unit.sv @@
`timescale 1ns / 1ps
// TGA (raw and RLE, 24/32-bit) decoder, top level. Depends on tgadec_pkg,
// tgadec_front, tgadec_queue and tgadec_back.
// Throughput: one file byte per cycle, sustained while the master side keeps up.
// Path: a result is written into the queue at the edge that accepts its byte,
// then registered in the output stage before it is valid on the master side.
// Reset: synchronous, active low; restarts the parser, empties queue and output.
module tga_rle_image_decoder_unit
    import tgadec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Slave side: tdata = data_byte[7:0]; tlast = end_of_file
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               s_axis_tlast,
    // Master side
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata, lowest bit up: image_width[15:0], image_height[31:16],
    // has_alpha[32], red[40:33], green[48:41], blue[56:49], alpha[64:57],
    // repeat_res[72:65], error_code[75:73], zero pad[79:76]
    output logic [TDATA_W-1:0] m_axis_tdata,
    // tuser: kind[1:0]
    output logic [TUSER_W-1:0] m_axis_tuser,
    // tlast: last pixel of the image, or any error
    output logic               m_axis_tlast
);

    logic    w_accept;
    logic    w_push;
    t_result w_front_result;
    logic    w_room;
    logic    w_q_valid;
    t_result w_q_result;
    logic    w_pop;

    // Take a byte whenever the queue can absorb a request; the output
    // register decouples this from the master's tready.
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid && w_room;

    // Parse the byte stream and raise at most one request per byte
    tgadec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (s_axis_tdata),
        .i_end_of_file (s_axis_tlast),
        .o_push        (w_push),
        .o_result      (w_front_result)
    );

    // Hold requests while the master side stalls
    tgadec_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_front_result),
        .o_room    (w_room),
        .o_valid   (w_q_valid),
        .o_rd_data (w_q_result),
        .i_pop     (w_pop)
    );

    // Register and pack results for the master side
    tgadec_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_result (w_q_result),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/tgadec_stream_checker.sv @@
`timescale 1ns / 1ps
// Checker for the TGA decoder streams: predicts each result from the accepted file bytes
// and compares it, field by field, with what leaves the master side. Depends on tgadec_pkg.
module tgadec_stream_checker
    import tgadec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,
    input  logic               i_s_tlast,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,
    input  logic [TUSER_W-1:0] i_m_tuser,
    input  logic               i_m_tlast,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Decoder state as seen from the byte stream
    t_phase      ph;
    logic [4:0]  hdr_pos;
    logic        rle_file;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        px4;
    logic [31:0] pix_left;
    logic [31:0] pkt_left;
    logic        pkt_run;
    logic [23:0] colour;
    logic [1:0]  byte_pos;

    t_result     awaited_results[$];
    int          fails = 0;

    task automatic clear_parser();
        ph       = PH_TYPE;
        hdr_pos  = '0;
        rle_file = 1'b0;
        img_w    = '0;
        img_h    = '0;
        px4      = 1'b0;
        pix_left = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        colour   = '0;
        byte_pos = '0;
    endtask

    task automatic abort_file(input t_err code, output t_result r);
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last       = 1'b1;
        ph           = PH_SKIP;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eof,
                               output bit got, output t_result r);
        bit          ok;
        logic [31:0] count;
        logic [31:0] rep;
        logic [1:0]  final_pos;
        got = 1'b0;
        r   = '0;
        case (ph)
            PH_TYPE: begin
                if (hdr_pos == HDR_TYPE_BYTE) begin
                    ok       = (b == TYPE_RAW) || (b == TYPE_RLE);
                    rle_file = (b == TYPE_RLE);
                end else begin
                    ok = (b == 8'd0);
                end
                if (!ok) begin
                    abort_file(ERR_TYPE, r);
                    got = 1'b1;
                end else begin
                    if (hdr_pos >= HDR_TYPE_LAST)
                        ph = PH_DIMS;
                    hdr_pos = hdr_pos + 5'd1;
                end
            end
            PH_DIMS: begin
                case (hdr_pos)
                    HDR_WIDTH_LO:  img_w = {8'd0, b};
                    HDR_WIDTH_HI:  img_w[15:8] = b;
                    HDR_HEIGHT_LO: img_h = {8'd0, b};
                    HDR_HEIGHT_HI: img_h[15:8] = b;
                    HDR_DEPTH: begin
                        px4 = (b == DEPTH_32);
                        if (img_w == 0 || img_h == 0 || (b != DEPTH_24 && b != DEPTH_32)) begin
                            abort_file(ERR_SIZE, r);
                            got = 1'b1;
                        end
                    end
                    default: begin
                        // descriptor byte: announce the image
                        r.kind         = KIND_INFO;
                        r.image_width  = img_w;
                        r.image_height = img_h;
                        r.has_alpha    = px4;
                        got            = 1'b1;
                        pix_left       = {16'd0, img_w};
                        pix_left       = pix_left * img_h;
                        byte_pos       = '0;
                        colour         = '0;
                        ph             = rle_file ? PH_PKT : PH_PIX;
                    end
                endcase
                if (ph == PH_DIMS)
                    hdr_pos = hdr_pos + 5'd1;
            end
            PH_PKT: begin
                // raw and run packets both carry count - 1 in the low seven bits
                count   = {25'd0, b[6:0]} + 32'd1;
                pkt_run = b[7];
                if (count > pix_left) begin
                    abort_file(ERR_OVERRUN, r);
                    got = 1'b1;
                end else begin
                    pkt_left = count;
                    byte_pos = '0;
                    colour   = '0;
                    ph       = PH_PIX;
                end
            end
            PH_PIX: begin
                final_pos = px4 ? 2'd3 : 2'd2;
                if (byte_pos < final_pos) begin
                    if (byte_pos == 0)
                        colour = '0;
                    colour[8*byte_pos +: 8] = b;
                    byte_pos = byte_pos + 2'd1;
                end else begin
                    rep = 32'd1;
                    if (rle_file && pkt_run)
                        rep = pkt_left;
                    if (rep > pix_left)
                        rep = pix_left;
                    r.kind       = KIND_PIXEL;
                    r.has_alpha  = px4;
                    r.blue       = colour[7:0];
                    r.green      = colour[15:8];
                    r.red        = px4 ? colour[23:16] : b;
                    r.alpha      = px4 ? b : 8'd0;
                    r.repeat_res = rep[7:0];
                    got          = 1'b1;
                    byte_pos     = '0;
                    pix_left     = pix_left - rep;
                    if (rle_file)
                        pkt_left = (rep > pkt_left) ? 32'd0 : pkt_left - rep;
                    if (pix_left == 0) begin
                        r.last = 1'b1;
                        ph     = PH_SKIP;
                    end else if (rle_file && pkt_left == 0) begin
                        ph = PH_PKT;
                    end
                end
            end
            default: ;
        endcase
        if (eof) begin
            if (ph != PH_SKIP) begin
                abort_file(ERR_SHORT, r);
                got = 1'b1;
            end
            clear_parser();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        bit      got;
        t_result made;
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            awaited_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast, got, made);
                if (got)
                    awaited_results.push_back(made);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result of kind %0d arrived with none awaited", i_m_tuser);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("image_width", want.image_width, i_m_tdata[15:0]);
                    check_field("image_height", want.image_height, i_m_tdata[31:16]);
                    check_field("has_alpha", want.has_alpha, i_m_tdata[32]);
                    check_field("red", want.red, i_m_tdata[40:33]);
                    check_field("green", want.green, i_m_tdata[48:41]);
                    check_field("blue", want.blue, i_m_tdata[56:49]);
                    check_field("alpha", want.alpha, i_m_tdata[64:57]);
                    check_field("repeat_res", want.repeat_res, i_m_tdata[72:65]);
                    check_field("error_code", want.error_code, i_m_tdata[75:73]);
                    check_field("last", want.last, i_m_tlast);
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the TGA decoder testbench: clock, reset, file stimulus and the verdict.
// Depends on tgadec_pkg, tga_rle_image_decoder_unit and tgadec_stream_checker.
module tb_top;
    import tgadec_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_BYTES   = 400;
    localparam int DRAIN_CYCLES   = 8;     // margin for stray results after the drain
    localparam int WATCHDOG_LIMIT = 5000;  // far above the longest gap plus stall

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;    // data_byte
    logic               s_axis_tlast  = 1'b0;  // end_of_file
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;          // image_width .. error_code, low bit up
    logic [TUSER_W-1:0] m_axis_tuser;          // kind
    logic               m_axis_tlast;

    int                 fail_count;
    int                 pending;
    int                 bytes_sent  = 0;
    int                 idle_cycles = 0;
    int                 stall_left  = 0;
    bit                 calm        = 1'b0;
    bit                 no_gaps     = 1'b0;
    logic [7:0]         tga_file[$];

    always #1 i_clk = ~i_clk;

    tga_rle_image_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tgadec_stream_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result sink: mostly ready, short stalls now and then, the odd long one,
    // and calm stretches where it never stalls at all.
    always @(posedge i_clk) begin : sink
        int roll;
        if ($urandom_range(0, 299) == 0)
            calm = !calm;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm) begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    stall_left = $urandom_range(1, 3);
                else if (roll < 18)
                    stall_left = $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: give up once nothing has moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Gap before a request: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic push_header(input logic [7:0] type_code, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] depth,
                               input logic [7:0] desc);
        for (int i = 0; i <= HDR_TYPE_LAST; i++)
            tga_file.push_back((i == HDR_TYPE_BYTE) ? type_code : 8'd0);
        tga_file.push_back(w[7:0]);
        tga_file.push_back(w[15:8]);
        tga_file.push_back(h[7:0]);
        tga_file.push_back(h[15:8]);
        tga_file.push_back(depth);
        tga_file.push_back(desc);
    endtask

    task automatic push_random(input int n);
        repeat (n) tga_file.push_back(8'($urandom_range(0, 255)));
    endtask

    // Pixel data for a well-formed image: plain bytes, or a packet sequence
    // that covers the image exactly
    task automatic push_body(input bit rle, input int total, input int bpp);
        int         left;
        int         count;
        logic [7:0] pkt;
        if (!rle) begin
            push_random(total * bpp);
        end else begin
            left = total;
            while (left > 0) begin
                count = $urandom_range(1, (left < 128) ? left : 128);
                if ($urandom_range(0, 1)) begin
                    pkt = 8'(127 + count);
                    tga_file.push_back(pkt);
                    push_random(bpp);
                end else begin
                    pkt = 8'(count - 1);
                    tga_file.push_back(pkt);
                    push_random(count * bpp);
                end
                left -= count;
            end
        end
    endtask

    // Build one random file: most well-formed, the rest cut short, corrupted
    // in the header, given bad dimensions, an overrunning packet, or noise
    task automatic make_random_file();
        int         sel;
        int         w;
        int         h;
        int         bpp;
        int         total;
        int         keep;
        int         count;
        bit         rle;
        logic [7:0] pkt;
        sel = $urandom_range(0, 99);
        rle = 1'($urandom_range(0, 1));
        bpp = $urandom_range(0, 1) ? 4 : 3;
        if (sel < 8) begin
            w = $urandom_range(8, 48);
            h = 1;
        end else begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 3);
        end
        total = w * h;
        push_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h),
                    (bpp == 4) ? DEPTH_32 : DEPTH_24, 8'($urandom_range(0, 255)));
        push_body(rle, total, bpp);
        // trailing footer bytes, ignored by the decoder
        if ($urandom_range(0, 3) == 0)
            push_random($urandom_range(1, 4));
        if (sel >= 70 && sel < 78) begin
            keep = $urandom_range(1, tga_file.size() - 1);
            while (tga_file.size() > keep)
                void'(tga_file.pop_back());
        end else if (sel >= 78 && sel < 84) begin
            tga_file[$urandom_range(0, HDR_DEPTH)] = 8'($urandom_range(0, 255));
        end else if (sel >= 84 && sel < 88) begin
            case ($urandom_range(0, 2))
                0: begin
                    tga_file[HDR_WIDTH_LO] = 8'd0;
                    tga_file[HDR_WIDTH_HI] = 8'd0;
                end
                1: begin
                    tga_file[HDR_HEIGHT_LO] = 8'd0;
                    tga_file[HDR_HEIGHT_HI] = 8'd0;
                end
                default: tga_file[HDR_DEPTH] = 8'($urandom_range(0, 255));
            endcase
        end else if (sel >= 88 && sel < 93 && rle && total < 128) begin
            // first packet claims more pixels than the image holds
            count = $urandom_range(total + 1, 128);
            pkt   = $urandom_range(0, 1) ? 8'(127 + count) : 8'(count - 1);
            tga_file[HDR_DEPTH + 2] = pkt;
        end else if (sel >= 96) begin
            tga_file.delete();
            if ($urandom_range(0, 1))
                tga_file.push_back(8'd0);
            push_random($urandom_range(1, 20));
        end
    endtask

    // Offer one request and hold it until the decoder takes it
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the built file, marking its final byte, and empty it
    task automatic send_file();
        for (int i = 0; i < tga_file.size(); i++)
            send_byte(tga_file[i], i == tga_file.size() - 1);
        tga_file.delete();
    endtask

    // Drop valid and hold off until every predicted result has drained
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wrong first byte, ending the file at once
        tga_file.push_back(8'hFF);
        send_file();
        // Type byte neither raw nor RLE; the bytes after it are ignored
        tga_file.push_back(8'd0);
        tga_file.push_back(8'd0);
        tga_file.push_back(8'd3);
        tga_file.push_back(8'd0);
        tga_file.push_back(8'd0);
        send_file();
        // Smallest raw image, one 24-bit pixel with byte extremes
        push_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24, 8'hFF);
        tga_file.push_back(8'h00);
        tga_file.push_back(8'hFF);
        tga_file.push_back(8'h80);
        send_file();
        // Largest dimensions in RLE 32-bit: a full run of 128, then the file
        // stops on the next packet header, so the stream is short
        push_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'd0);
        tga_file.push_back(8'hFF);
        tga_file.push_back(8'hFF);
        tga_file.push_back(8'h00);
        tga_file.push_back(8'hFF);
        tga_file.push_back(8'h00);
        tga_file.push_back(8'h7F);
        send_file();
        // Depth other than 24 or 32
        push_header(TYPE_RAW, 16'd2, 16'd1, 8'd16, 8'd0);
        send_file();
        // Zero width
        push_header(TYPE_RLE, 16'd0, 16'd5, DEPTH_24, 8'd0);
        send_file();
        // Run packet longer than the image
        push_header(TYPE_RLE, 16'd2, 16'd1, DEPTH_24, 8'd0);
        tga_file.push_back(8'h82);
        push_random(3);
        send_file();
        // File ends on the descriptor byte: the image-info result turns short
        push_header(TYPE_RAW, 16'd3, 16'd2, DEPTH_32, 8'd0);
        send_file();
        // File ends inside the type header
        repeat (2) tga_file.push_back(8'd0);
        tga_file.push_back(TYPE_RLE);
        repeat (3) tga_file.push_back(8'd0);
        send_file();
        // Raw 32-bit image followed by footer bytes
        push_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_32, 8'd0);
        push_random(8 + 3);
        send_file();
        // RLE 24-bit: a raw packet of two, then a run of one
        push_header(TYPE_RLE, 16'd3, 16'd1, DEPTH_24, 8'd0);
        tga_file.push_back(8'h01);
        push_random(6);
        tga_file.push_back(8'h80);
        push_random(3);
        send_file();
        settle();

        // Random files, sometimes back to back without gaps
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            make_random_file();
            send_file();
            if ($urandom_range(0, 9) == 0)
                settle();
        end

        // Drain: wait for the last results, then a margin for strays
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
